[design/ssd_pkg.sv]
// Shared constants, types and lookup functions for the seven-segment scan driver.
package ssd_pkg;

  localparam int MAG_W   = 17;
  localparam int SEG_W   = 8;
  localparam int DIG_N   = 4;
  localparam int POS_W   = 2;
  localparam int WHICH_W = 3;
  localparam int DIGIT_W = 4;
  localparam int RECIP_W = 18;
  localparam int SHIFT_W = 5;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int QUO10_W = 14;

  localparam logic [MAG_W-1:0] MAG_MAX    = 17'd99999;
  localparam logic [MAG_W-1:0] THR_TENTHOU = 17'd10000;
  localparam logic [MAG_W-1:0] THR_THOU    = 17'd1000;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'hff;
  localparam logic [SEG_W-1:0] SEG_MINUS = 8'hbf;
  localparam logic [SEG_W-1:0] DP_MASK   = 8'h7f;

  // Digit slot that carries the decimal point (ones)
  localparam logic [WHICH_W-1:0] WHICH_ONES = 3'd2;

  // Exact divide-by-ten for any 17-bit value: (x * M) >> S
  localparam logic [RECIP_W-1:0] DIV10_MULT  = 18'd209716;
  localparam int                 DIV10_SHIFT = 21;

  typedef logic [PROD_W-1:0] prod_t;

  // Control fields that travel down the pipeline beside the data
  typedef struct packed {
    logic               neg;
    logic               mode;
    logic [POS_W-1:0]   pos;
    logic [WHICH_W-1:0] which;
    logic [1:0]         first;
  } ssd_ctl_t;

  // Reciprocal multiplier for the divisor of digit slot "which"
  // (slot 0 hundreds .. slot 4 hundredths; divisors 10000, 1000, 100, 10, 1)
  function automatic logic [RECIP_W-1:0] recip_mult(input logic [WHICH_W-1:0] which);
    logic [RECIP_W-1:0] m;
    unique case (which)
      3'd0:    m = 18'd214749;
      3'd1:    m = 18'd134218;
      3'd2:    m = 18'd167773;
      3'd3:    m = 18'd209716;
      default: m = 18'd131072;
    endcase
    return m;
  endfunction

  // Matching right shift for the reciprocal above
  function automatic logic [SHIFT_W-1:0] recip_shift(input logic [WHICH_W-1:0] which);
    logic [SHIFT_W-1:0] s;
    unique case (which)
      3'd0:    s = 5'd31;
      3'd1:    s = 5'd27;
      3'd2:    s = 5'd24;
      3'd3:    s = 5'd21;
      default: s = 5'd17;
    endcase
    return s;
  endfunction

  // Active-low glyphs for decimal digits
  function automatic logic [SEG_W-1:0] glyph(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] g;
    unique case (digit)
      4'd0:    g = 8'hc0;
      4'd1:    g = 8'hf9;
      4'd2:    g = 8'ha4;
      4'd3:    g = 8'hb0;
      4'd4:    g = 8'h99;
      4'd5:    g = 8'h92;
      4'd6:    g = 8'h82;
      4'd7:    g = 8'hf8;
      4'd8:    g = 8'h80;
      4'd9:    g = 8'h90;
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

endpackage

[design/ssd_in_if.sv]
// Request channel carrying sign flag and magnitude.
interface ssd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      negative;
  logic [ssd_pkg::MAG_W-1:0] magnitude;

  modport source (output valid, output negative, output magnitude, input ready);
  modport sink   (input valid, input negative, input magnitude, output ready);
endinterface

[design/ssd_out_if.sv]
// Result channel carrying segment pattern and digit enables.
interface ssd_out_if;
  logic                      valid;
  logic                      ready;
  logic [ssd_pkg::SEG_W-1:0] segments;
  logic [ssd_pkg::DIG_N-1:0] digit_enable;

  modport source (output valid, output segments, output digit_enable, input ready);
  modport sink   (input valid, input segments, input digit_enable, output ready);
endinterface

[design/ssd_digit_extract.sv]
// Two-stage decimal digit extraction by reciprocal multiplication.
module ssd_digit_extract (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [ssd_pkg::MAG_W-1:0]     in_mag,
  input  ssd_pkg::ssd_ctl_t             in_ctl,
  output logic                          dig_valid,
  output logic [ssd_pkg::DIGIT_W-1:0]   dig_value,
  output ssd_pkg::ssd_ctl_t             dig_ctl
);

  logic                           q_valid_r;
  logic [ssd_pkg::MAG_W-1:0]      q_r;
  ssd_pkg::ssd_ctl_t              q_ctl_r;
  logic                           d_valid_r;
  logic [ssd_pkg::DIGIT_W-1:0]    d_r;
  ssd_pkg::ssd_ctl_t              d_ctl_r;

  ssd_pkg::prod_t                 q_prod;
  ssd_pkg::prod_t                 q_shifted;
  logic [ssd_pkg::MAG_W-1:0]      q_nxt;
  ssd_pkg::prod_t                 t_prod;
  logic [ssd_pkg::QUO10_W-1:0]    tens;
  logic [ssd_pkg::MAG_W-1:0]      tens_x10;
  logic [ssd_pkg::MAG_W-1:0]      rem;

  // Quotient of magnitude by the selected power of ten
  always_comb begin
    q_prod    = ssd_pkg::prod_t'(in_mag) *
                ssd_pkg::prod_t'(ssd_pkg::recip_mult(in_ctl.which));
    q_shifted = q_prod >> ssd_pkg::recip_shift(in_ctl.which);
    q_nxt     = q_shifted[ssd_pkg::MAG_W-1:0];
  end

  // Quotient mod ten gives the digit
  always_comb begin
    t_prod   = ssd_pkg::prod_t'(q_r) * ssd_pkg::prod_t'(ssd_pkg::DIV10_MULT);
    tens     = t_prod[ssd_pkg::DIV10_SHIFT +: ssd_pkg::QUO10_W];
    tens_x10 = (ssd_pkg::MAG_W'(tens) << 3) + (ssd_pkg::MAG_W'(tens) << 1);
    rem      = q_r - tens_x10;
  end

  // Advance both stages together when the pipeline moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else if (en) begin
      q_valid_r <= in_valid;
      d_valid_r <= q_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r     <= q_nxt;
      q_ctl_r <= in_ctl;
      d_r     <= rem[ssd_pkg::DIGIT_W-1:0];
      d_ctl_r <= q_ctl_r;
    end
  end

  assign dig_valid = d_valid_r;
  assign dig_value = d_r;
  assign dig_ctl   = d_ctl_r;

endmodule

[design/ssd_glyph_out.sv]
// Glyph lookup, decimal point, blanking and sign overlay, and the result register.
module ssd_glyph_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          dig_valid,
  input  logic [ssd_pkg::DIGIT_W-1:0]   dig_value,
  input  ssd_pkg::ssd_ctl_t             dig_ctl,
  ssd_out_if.source                     out_res
);

  logic                          out_valid_r;
  logic [ssd_pkg::SEG_W-1:0]     seg_r;
  logic [ssd_pkg::DIG_N-1:0]     den_r;
  logic [ssd_pkg::SEG_W-1:0]     seg_nxt;
  logic [ssd_pkg::DIG_N-1:0]     den_nxt;

  // Build the segment pattern for this scan position
  always_comb begin
    seg_nxt = ssd_pkg::glyph(dig_value);
    if (dig_ctl.which == ssd_pkg::WHICH_ONES) begin
      seg_nxt = seg_nxt & ssd_pkg::DP_MASK;
    end
    if (!dig_ctl.mode) begin
      if (dig_ctl.pos < dig_ctl.first) begin
        seg_nxt = ssd_pkg::SEG_BLANK;
      end
      if (dig_ctl.pos == '0 && dig_ctl.neg) begin
        seg_nxt = ssd_pkg::SEG_MINUS;
      end
    end
    den_nxt = ssd_pkg::DIG_N'(1) << dig_ctl.pos;
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dig_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_r <= seg_nxt;
      den_r <= den_nxt;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.segments     = seg_r;
  assign out_res.digit_enable = den_r;

endmodule

[design/seven_segment_scan_driver.sv]
// Top level of the four-digit multiplexed seven-segment scan driver.
// Each accepted request (sign flag plus magnitude in hundredths, clamped to
// 99999) drives one digit at the current scan position 0..3, then the
// position advances. The block is a four-stage pipeline: input register,
// selected-power-of-ten quotient, mod-ten digit, glyph and result register.
// It takes one request per clock unless a held result is waiting to be taken;
// the two reciprocal multiplies each own a stage. Mode 0 shows
// hundreds..tenths with leading-zero blanking and a minus sign on digit 0;
// mode 1 (reset value) shows tens..hundredths. The decimal point is lit on
// the ones digit. Write the mode only while idle.
module seven_segment_scan_driver (
  input  logic        clk,
  input  logic        rst_n,
  ssd_in_if.sink      in_req,
  ssd_out_if.source   out_res,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  logic                           en;
  logic                           accept;
  logic                           mode_r;
  logic [ssd_pkg::POS_W-1:0]      scan_pos_r;

  logic                           s1_valid_r;
  logic                           s1_neg_r;
  logic [ssd_pkg::MAG_W-1:0]      s1_mag_r;
  logic [ssd_pkg::POS_W-1:0]      s1_pos_r;
  logic [ssd_pkg::MAG_W-1:0]      mag_sat;
  ssd_pkg::ssd_ctl_t              s1_ctl;

  logic                           dig_valid;
  logic [ssd_pkg::DIGIT_W-1:0]    dig_value;
  ssd_pkg::ssd_ctl_t              dig_ctl;

  // Move the whole pipeline when the result register is free or drained
  assign en           = !out_res.valid || out_res.ready;
  assign in_req.ready = en;
  assign accept       = in_req.valid && en;

  // Clamp large magnitudes
  assign mag_sat = (in_req.magnitude > ssd_pkg::MAG_MAX) ? ssd_pkg::MAG_MAX
                                                         : in_req.magnitude;

  // Hold the display mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Advance the scan position on every accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_pos_r <= '0;
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_req.valid;
      if (accept) begin
        scan_pos_r <= scan_pos_r + ssd_pkg::POS_W'(1);
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg_r <= in_req.negative;
      s1_mag_r <= mag_sat;
      s1_pos_r <= scan_pos_r;
    end
  end

  // Digit slot, first shown digit and sign for the stages below
  always_comb begin
    s1_ctl.neg   = s1_neg_r;
    s1_ctl.mode  = mode_r;
    s1_ctl.pos   = s1_pos_r;
    s1_ctl.which = ssd_pkg::WHICH_W'(s1_pos_r) + ssd_pkg::WHICH_W'(mode_r);
    if (s1_mag_r >= ssd_pkg::THR_TENTHOU) begin
      s1_ctl.first = 2'd0;
    end else if (s1_mag_r >= ssd_pkg::THR_THOU) begin
      s1_ctl.first = 2'd1;
    end else begin
      s1_ctl.first = 2'd2;
    end
  end

  ssd_digit_extract u_digit (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s1_valid_r),
    .in_mag    (s1_mag_r),
    .in_ctl    (s1_ctl),
    .dig_valid (dig_valid),
    .dig_value (dig_value),
    .dig_ctl   (dig_ctl)
  );

  ssd_glyph_out u_glyph (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .dig_valid (dig_valid),
    .dig_value (dig_value),
    .dig_ctl   (dig_ctl),
    .out_res   (out_res)
  );

endmodule
